// ----- rtl/yc420_pkg.sv -----
// ----------------------------------------------------------------------------
// YCbCr 4:2:2 to 4:2:0 level expansion - shared definitions
// Types, constants and the level mapping function used by the core and its
// sub-blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package yc420_pkg;

    // Largest row length in pixel pairs; longer settings are limited to it.
    localparam int MAX_PAIRS = 2048;

    // Width of the column counter, which counts 0 .. MAX_PAIRS-1.
    localparam int COL_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    // Width of the row length register.
    localparam int PPR_W = 12;

    // Width used to compare the column counter against the last column.
    localparam int CMP_W = ((COL_W > PPR_W) ? COL_W : PPR_W) + 1;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PAIRS_PER_ROW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPAND_LEVELS = 1'b1;

    // Reset values of the registers.
    localparam logic [PPR_W-1:0] PAIRS_PER_ROW_RST = 12'd960;
    localparam logic             EXPAND_LEVELS_RST = 1'b1;

    // Level expansion: black level and Q16 gains (255/219 and 255/224).
    localparam int GAIN_W = 17;
    localparam logic [7:0]        LEVEL_BASE  = 8'd16;
    localparam logic [GAIN_W-1:0] LUMA_GAIN   = 17'd76309;
    localparam logic [GAIN_W-1:0] CHROMA_GAIN = 17'd74606;

    // One 4:2:2 pixel pair.
    typedef struct packed {
        logic [7:0] cb_in;
        logic [7:0] luma_a_in;
        logic [7:0] cr_in;
        logic [7:0] luma_b_in;
    } t_in_item;

    // One 4:2:0 result.
    typedef struct packed {
        logic [7:0] luma_a_out;
        logic [7:0] luma_b_out;
        logic [7:0] cb_out;
        logic [7:0] cr_out;
        logic       chroma_valid;
        logic       row_end;
    } t_out_item;

    // Row position of the pair being accepted.
    typedef struct packed {
        logic chroma_on;
        logic last;
    } t_row_flags;

    // Expands one video-range value to full range with clamping.
    function automatic logic [7:0] expand_value(input logic [7:0] v,
                                                input logic [GAIN_W-1:0] gain);
        logic [7:0]          d;
        logic [GAIN_W+7:0]   p;
        logic [8:0]          q;
        logic [7:0]          r;
        d = v - LEVEL_BASE;
        p = {{GAIN_W{1'b0}}, d} * {8'd0, gain};
        q = p[16 +: 9];
        if (v <= LEVEL_BASE) begin
            r = 8'd0;
        end else if (q[8]) begin
            r = 8'hFF;
        end else begin
            r = q[7:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/yc420_row_track.sv -----
// ----------------------------------------------------------------------------
// YCbCr 4:2:0 row tracker
// Counts pixel pairs along a row and keeps the row parity; flags the last
// pair of each row and whether the current row keeps its chroma.
// ----------------------------------------------------------------------------
`default_nettype none

module yc420_row_track (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [yc420_pkg::PPR_W-1:0] i_pairs_per_row,
    output yc420_pkg::t_row_flags            o_flags
);

    logic [yc420_pkg::COL_W-1:0] r_col;
    logic [yc420_pkg::COL_W-1:0] n_col;
    logic                        r_odd;
    logic                        n_odd;
    logic [yc420_pkg::CMP_W-1:0] pairs_ext;
    logic [yc420_pkg::CMP_W-1:0] last_col;
    logic                        last;

    // Limit the row length to 1 .. MAX_PAIRS and find the last column.
    always_comb begin
        pairs_ext = {{(yc420_pkg::CMP_W-yc420_pkg::PPR_W){1'b0}}, i_pairs_per_row};
        if (pairs_ext == '0) begin
            last_col = '0;
        end else if (pairs_ext > yc420_pkg::CMP_W'(yc420_pkg::MAX_PAIRS)) begin
            last_col = yc420_pkg::CMP_W'(yc420_pkg::MAX_PAIRS - 1);
        end else begin
            last_col = pairs_ext - yc420_pkg::CMP_W'(1);
        end
        last = {{(yc420_pkg::CMP_W-yc420_pkg::COL_W){1'b0}}, r_col} >= last_col;
    end

    // Advance the column, or wrap and flip the row parity at row end.
    always_comb begin
        n_col = r_col;
        n_odd = r_odd;
        if (i_accept) begin
            if (last) begin
                n_col = '0;
                n_odd = ~r_odd;
            end else begin
                n_col = r_col + yc420_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_odd <= 1'b0;
        end else begin
            r_col <= n_col;
            r_odd <= n_odd;
        end
    end

    assign o_flags.chroma_on = ~r_odd;
    assign o_flags.last      = last;

endmodule

`default_nettype wire

// ----- rtl/yc420_level_map.sv -----
// ----------------------------------------------------------------------------
// YCbCr 4:2:0 level mapper
// Expands the four samples of a pair to full range when enabled and drops
// the chroma on odd rows.
// ----------------------------------------------------------------------------
`default_nettype none

module yc420_level_map (
    input  wire yc420_pkg::t_in_item   i_item,
    input  wire yc420_pkg::t_row_flags i_flags,
    input  wire logic                  i_expand,
    output yc420_pkg::t_out_item       o_item
);

    logic [7:0] luma_a;
    logic [7:0] luma_b;
    logic [7:0] cb;
    logic [7:0] cr;

    // Map each sample: expanded with clamping, or passed through.
    always_comb begin
        if (i_expand) begin
            luma_a = yc420_pkg::expand_value(i_item.luma_a_in, yc420_pkg::LUMA_GAIN);
            luma_b = yc420_pkg::expand_value(i_item.luma_b_in, yc420_pkg::LUMA_GAIN);
            cb     = yc420_pkg::expand_value(i_item.cb_in, yc420_pkg::CHROMA_GAIN);
            cr     = yc420_pkg::expand_value(i_item.cr_in, yc420_pkg::CHROMA_GAIN);
        end else begin
            luma_a = i_item.luma_a_in;
            luma_b = i_item.luma_b_in;
            cb     = i_item.cb_in;
            cr     = i_item.cr_in;
        end
    end

    // Chroma is kept on even rows only; on odd rows it reads as zero.
    always_comb begin
        o_item.luma_a_out   = luma_a;
        o_item.luma_b_out   = luma_b;
        o_item.cb_out       = i_flags.chroma_on ? cb : 8'd0;
        o_item.cr_out       = i_flags.chroma_on ? cr : 8'd0;
        o_item.chroma_valid = i_flags.chroma_on;
        o_item.row_end      = i_flags.last;
    end

endmodule

`default_nettype wire

// ----- rtl/ycbcr422_to_420_level_expand_core.sv -----
// ----------------------------------------------------------------------------
// YCbCr 4:2:2 to 4:2:0 converter with level expansion
// Takes one 4:2:2 pixel pair (Cb, Y0, Cr, Y1) per transaction on the input
// channel and gives one result per pair on the output channel: both lumas,
// and the chroma on even rows only (4:2:0 vertical subsampling). With level
// expansion enabled each sample is mapped from video range to 0..255.
//
// Both channels are valid/ready. A pair is registered on acceptance together
// with its row position; the mapping runs between that register and the
// output register, from which the result is presented. One pair per cycle
// is sustained while the receiver takes results; the output register and
// the input register each hold a transaction, so the input can still take
// one transaction while a finished result waits, and both back up when the
// receiver stalls.
// The configuration port (row length in pairs, level expansion enable) is
// written with no wait; it should change only while the block is empty.
// Synchronous reset empties both stages, sets the column to zero and the
// row to even, and loads 960 pairs per row with expansion enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module ycbcr422_to_420_level_expand_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration write port.
    input  wire logic                             i_cfg_we,
    input  wire logic [yc420_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [yc420_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire yc420_pkg::t_in_item              i_in_data,
    // Output channel.
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output yc420_pkg::t_out_item                  o_out_data
);

    logic [yc420_pkg::PPR_W-1:0] r_pairs_per_row;
    logic                        r_expand;

    logic                  r_s1_valid;
    yc420_pkg::t_in_item   r_s1_data;
    yc420_pkg::t_row_flags r_s1_flags;
    logic                  r_s2_valid;
    yc420_pkg::t_out_item  r_s2_data;

    logic                  in_accept;
    logic                  s1_ready;
    logic                  s2_ready;
    yc420_pkg::t_row_flags row_flags;
    yc420_pkg::t_out_item  mapped;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs_per_row <= yc420_pkg::PAIRS_PER_ROW_RST;
            r_expand        <= yc420_pkg::EXPAND_LEVELS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                yc420_pkg::CFG_PAIRS_PER_ROW: begin
                    r_pairs_per_row <= i_cfg_data[yc420_pkg::PPR_W-1:0];
                end
                yc420_pkg::CFG_EXPAND_LEVELS: begin
                    r_expand <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow control: a stage loads when empty or when it moves on.
    assign s2_ready   = ~r_s2_valid | i_out_ready;
    assign s1_ready   = ~r_s1_valid | s2_ready;
    assign o_in_ready = s1_ready;
    assign in_accept  = i_in_valid & s1_ready;

    yc420_row_track u_row_track (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_pairs_per_row (r_pairs_per_row),
        .o_flags         (row_flags)
    );

    // Input stage: the pair and its row position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_data  <= i_in_data;
            r_s1_flags <= row_flags;
        end
    end

    yc420_level_map u_level_map (
        .i_item   (r_s1_data),
        .i_flags  (r_s1_flags),
        .i_expand (r_expand),
        .o_item   (mapped)
    );

    // Output stage: the finished result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_data <= mapped;
        end
    end

    assign o_out_valid = r_s2_valid;
    assign o_out_data  = r_s2_data;

    // Odd-row results never carry chroma.
    a_odd_row_no_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.chroma_valid)
            |-> (o_out_data.cb_out == 8'd0 && o_out_data.cr_out == 8'd0))
        else $error("chroma present on an odd-row result");

    // Accepting the last pair of a row flips the row parity.
    a_row_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && row_flags.last)
            |=> (row_flags.chroma_on != $past(row_flags.chroma_on)))
        else $error("row parity did not flip at row end");

    // Any other accepted pair leaves the row parity alone.
    a_row_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !row_flags.last) |=> $stable(row_flags.chroma_on))
        else $error("row parity changed mid-row");

endmodule

`default_nettype wire

// ----- tb/tb_ycbcr422_to_420_level_expand_core.sv -----
// ----------------------------------------------------------------------------
// Testbench for the YCbCr 4:2:2 to 4:2:0 level expansion core
// Pixel pairs are fed from a queue through a bursty valid/ready driver. The
// output is taken by a receiver that stalls on its own pattern. Each pair
// accepted by the core is run through a local model of the row tracking and
// the level mapping, and each result transaction is checked field by field
// against the oldest prediction. Row lengths and the expansion enable are
// changed between phases, once the core has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ycbcr422_to_420_level_expand_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 48;
    localparam int ITEMS_PER_PHASE = 72;
    localparam int NUM_PHASES      = 6;

    // Row lengths and expansion settings for the random phases.
    int unsigned phase_rows [NUM_PHASES] = '{1, 3, 2048, 5, 16, 0};
    bit          phase_expand [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [yc420_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [yc420_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    yc420_pkg::t_in_item              in_data = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    yc420_pkg::t_out_item             out_data;

    // Pairs waiting to be offered, and results predicted but not yet seen.
    yc420_pkg::t_in_item  pending_pairs [$];
    yc420_pkg::t_out_item predicted_results [$];

    // Local copy of the core's registers and row position.
    logic [yc420_pkg::PPR_W-1:0] row_pairs = yc420_pkg::PAIRS_PER_ROW_RST;
    logic                        expand_on = yc420_pkg::EXPAND_LEVELS_RST;
    int unsigned                 column_pos = 0;
    logic                        odd_row = 1'b0;

    // Sender pacing.
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    // Receiver pacing; a toggle on hold_trigger starts a long hold-off.
    logic        hold_trigger = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;
    logic [7:0]  rx_cycle = '0;

    // Run statistics.
    int unsigned pairs_sent = 0;
    int unsigned results_checked = 0;
    int unsigned row_ends_seen = 0;
    int unsigned chroma_kept = 0;
    int unsigned cfg_writes = 0;
    int unsigned errors = 0;

    ycbcr422_to_420_level_expand_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // Clock with a 20 ns period.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Maps one sample from video range to full range when expansion is on.
    function automatic logic [7:0] level_map(input logic [7:0] v,
                                             input logic [yc420_pkg::GAIN_W-1:0] gain);
        logic [24:0] prod;
        logic [8:0]  scaled;
        if (!expand_on) begin
            return v;
        end
        if (v <= yc420_pkg::LEVEL_BASE) begin
            return 8'd0;
        end
        prod   = 25'(v - yc420_pkg::LEVEL_BASE) * 25'(gain);
        scaled = prod[24:16] > 9'd255 ? 9'd255 : prod[24:16];
        return scaled[7:0];
    endfunction

    // Works out the result for one accepted pair and advances the row position.
    function automatic yc420_pkg::t_out_item convert_pair(input yc420_pkg::t_in_item px);
        yc420_pkg::t_out_item res;
        int unsigned          len;
        logic                 last;
        len  = (row_pairs == 0) ? 1 :
               ((row_pairs > yc420_pkg::MAX_PAIRS) ? yc420_pkg::MAX_PAIRS : row_pairs);
        last = (column_pos >= len - 1);
        res.luma_a_out   = level_map(px.luma_a_in, yc420_pkg::LUMA_GAIN);
        res.luma_b_out   = level_map(px.luma_b_in, yc420_pkg::LUMA_GAIN);
        res.cb_out       = odd_row ? 8'd0 : level_map(px.cb_in, yc420_pkg::CHROMA_GAIN);
        res.cr_out       = odd_row ? 8'd0 : level_map(px.cr_in, yc420_pkg::CHROMA_GAIN);
        res.chroma_valid = ~odd_row;
        res.row_end      = last;
        if (last) begin
            column_pos = 0;
            odd_row    = ~odd_row;
        end else begin
            column_pos = column_pos + 1;
        end
        return res;
    endfunction

    // Random sample, biased towards the clamping boundaries now and then.
    function automatic logic [7:0] rand_sample();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 20));
            1:       return 8'($urandom_range(225, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic yc420_pkg::t_in_item rand_pair();
        yc420_pkg::t_in_item px;
        px.cb_in     = rand_sample();
        px.luma_a_in = rand_sample();
        px.cr_in     = rand_sample();
        px.luma_b_in = rand_sample();
        return px;
    endfunction

    function automatic yc420_pkg::t_in_item make_pair(input logic [7:0] cb,
                                                      input logic [7:0] ya,
                                                      input logic [7:0] cr,
                                                      input logic [7:0] yb);
        yc420_pkg::t_in_item px;
        px.cb_in     = cb;
        px.luma_a_in = ya;
        px.cr_in     = cr;
        px.luma_b_in = yb;
        return px;
    endfunction

    // Writes one register; only called while the core is empty.
    task automatic write_reg(input logic [yc420_pkg::CFG_IDX_W-1:0] idx,
                             input logic [yc420_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == yc420_pkg::CFG_PAIRS_PER_ROW) begin
            row_pairs = value[yc420_pkg::PPR_W-1:0];
        end else if (idx == yc420_pkg::CFG_EXPAND_LEVELS) begin
            expand_on = value[0];
        end
        cfg_writes++;
    endtask

    // Holds the stimulus back until every queued pair is sent and every predicted result has arrived.
    task automatic wait_drained();
        do begin
            @(negedge clk);
        end while (pending_pairs.size() != 0 || in_valid || predicted_results.size() != 0);
    endtask

    // Input driver: offers queued pairs in bursts with random gaps.
    always @(posedge clk) begin : pair_driver
        logic take;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            take = in_valid && in_ready;
            if (take) begin
                predicted_results.push_back(convert_pair(in_data));
                pairs_sent++;
            end
            if (!in_valid || take) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_pairs.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver pacing: a rotating stall pattern, plus long hold-offs on request.
    always @(posedge clk) begin : sink_pacing
        if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_OFF_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 8'd1;
            case (rx_cycle[6:5])
                2'd0:    out_ready <= 1'b1;
                2'd1:    out_ready <= $urandom_range(0, 1);
                2'd2:    out_ready <= (rx_cycle % 3 == 0);
                default: out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Result checker: each transaction against the oldest prediction.
    always @(posedge clk) begin : result_monitor
        yc420_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (predicted_results.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: result with nothing predicted: %h", out_data);
                end
            end else begin
                want = predicted_results.pop_front();
                results_checked++;
                if (out_data.row_end) row_ends_seen++;
                if (out_data.chroma_valid) chroma_kept++;
                if (out_data !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("ERROR: result %0d: want Y %h/%h C %h/%h cv %b re %b",
                                 results_checked,
                                 want.luma_a_out, want.luma_b_out, want.cb_out, want.cr_out,
                                 want.chroma_valid, want.row_end);
                        $display("       got Y %h/%h C %h/%h cv %b re %b",
                                 out_data.luma_a_out, out_data.luma_b_out, out_data.cb_out,
                                 out_data.cr_out, out_data.chroma_valid, out_data.row_end);
                    end
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin : stimulus
        int unsigned mark;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: sample extremes around the black level and the clamp.
        pending_pairs.push_back(make_pair(8'd0, 8'd0, 8'd0, 8'd0));
        pending_pairs.push_back(make_pair(8'd255, 8'd255, 8'd255, 8'd255));
        pending_pairs.push_back(make_pair(8'd16, 8'd16, 8'd16, 8'd16));
        pending_pairs.push_back(make_pair(8'd17, 8'd17, 8'd17, 8'd17));
        pending_pairs.push_back(make_pair(8'd15, 8'd235, 8'd240, 8'd254));
        pending_pairs.push_back(make_pair(8'd240, 8'd236, 8'd241, 8'd128));
        pending_pairs.push_back(make_pair(8'd128, 8'd1, 8'd128, 8'd234));
        wait_drained();

        // A zero row length behaves as one pair, so every pair ends a row.
        write_reg(yc420_pkg::CFG_PAIRS_PER_ROW, 12'd0);
        write_reg(yc420_pkg::CFG_EXPAND_LEVELS, 12'd0);
        pending_pairs.push_back(make_pair(8'h00, 8'hFF, 8'hFF, 8'h00));
        pending_pairs.push_back(make_pair(8'hFF, 8'h00, 8'h00, 8'hFF));
        pending_pairs.push_back(make_pair(8'hAA, 8'h55, 8'h55, 8'hAA));
        pending_pairs.push_back(make_pair(8'h55, 8'hAA, 8'hAA, 8'h55));
        wait_drained();

        // An oversized row length is limited; then the row is shrunk mid-row.
        write_reg(yc420_pkg::CFG_PAIRS_PER_ROW, 12'hFFF);
        write_reg(yc420_pkg::CFG_EXPAND_LEVELS, 12'd1);
        repeat (4) pending_pairs.push_back(rand_pair());
        wait_drained();
        write_reg(yc420_pkg::CFG_PAIRS_PER_ROW, 12'd2);
        repeat (3) pending_pairs.push_back(rand_pair());
        wait_drained();

        // Random phases over a range of row lengths and both mapping modes.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(yc420_pkg::CFG_PAIRS_PER_ROW, 12'(phase_rows[p]));
            write_reg(yc420_pkg::CFG_EXPAND_LEVELS, 12'(phase_expand[p]));
            repeat (ITEMS_PER_PHASE) pending_pairs.push_back(rand_pair());
            if (p == 1) begin
                // Long receiver hold-off while the sender keeps offering.
                mark = pairs_sent;
                do begin
                    @(negedge clk);
                end while (pairs_sent < mark + 10);
                hold_trigger <= ~hold_trigger;
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        $display("Checked %0d results from %0d pairs over %0d register writes.",
                 results_checked, pairs_sent, cfg_writes);
        $display("Rows ended %0d times; chroma kept on %0d results; %0d mismatches.",
                 row_ends_seen, chroma_kept, errors);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #4000000;
        $display("ERROR: timeout");
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/yc420_pkg.sv
rtl/yc420_row_track.sv
rtl/yc420_level_map.sv
rtl/ycbcr422_to_420_level_expand_core.sv
tb/tb_ycbcr422_to_420_level_expand_core.sv
